// ===== sv/scg_pkg.sv =====
// Shared types, constants and helper functions for the submask candidate generator.
package scg_pkg;

	localparam int MaskWidth = 16;
	localparam int CntWidth  = $clog2(MaskWidth + 1);
	localparam int IdxWidth  = $clog2(MaskWidth);

	typedef logic [MaskWidth-1:0] mask_t;
	typedef logic [CntWidth-1:0]  cnt_t;
	typedef logic [IdxWidth-1:0]  idx_t;

	typedef enum logic {
		ModeLoad = 1'b0,
		ModeNext = 1'b1
	} mode_t;

	typedef struct packed {
		mode_t mode;
		mask_t mask;
	} item_t;

	typedef struct packed {
		mask_t candidate;
		cnt_t  weight;
		logic  last;
	} result_t;

	function automatic cnt_t count_ones(mask_t v);
		cnt_t c;
		c = '0;
		for (int i = 0; i < MaskWidth; i++) begin
			c = c + cnt_t'(v[i]);
		end
		return c;
	endfunction

	function automatic mask_t low_mask(cnt_t n);
		mask_t m;
		for (int i = 0; i < MaskWidth; i++) begin
			m[i] = (cnt_t'(i) < n);
		end
		return m;
	endfunction

endpackage

// ===== sv/scg_advance.sv =====
// Next compressed pattern: same-weight successor, next weight's first, else empty.
module scg_advance import scg_pkg::*; (
	input  mask_t pattern,
	input  cnt_t  weight,
	input  cnt_t  ones,
	output mask_t next_pattern,
	output cnt_t  next_weight
);

	mask_t top;
	mask_t lowest;
	mask_t ripple;
	idx_t  tz;

	always_comb begin
		top    = low_mask(ones) ^ low_mask(ones - weight);
		lowest = pattern & mask_t'(~pattern + mask_t'(1));
		ripple = pattern + lowest;
		tz     = '0;
		for (int i = 0; i < MaskWidth; i++) begin
			tz = tz | (lowest[i] ? idx_t'(i) : idx_t'(0));
		end
		if (weight >= ones) begin
			next_pattern = '0;
			next_weight  = '0;
		end else if (pattern == top) begin
			next_weight  = weight + cnt_t'(1);
			next_pattern = low_mask(weight + cnt_t'(1));
		end else begin
			next_weight  = weight;
			next_pattern = (((ripple ^ pattern) >> 2) >> tz) | ripple;
		end
	end

endmodule

// ===== sv/scg_deposit.sv =====
// Bit deposit: scatters the low bits of a pattern into the set positions of a mask.
module scg_deposit import scg_pkg::*; (
	input  mask_t bits,
	input  mask_t positions,
	output mask_t deposited
);

	cnt_t prefix [MaskWidth];

	always_comb begin
		for (int p = 0; p < MaskWidth; p++) begin
			prefix[p]    = count_ones(positions & low_mask(cnt_t'(p)));
			deposited[p] = positions[p] & bits[prefix[p][IdxWidth-1:0]];
		end
	end

endmodule

// ===== sv/submask_candidate_generator.sv =====
// Top level of the submask candidate generator with input and result registers.
// An accepted item is held in the input register; the result of a next item is
// registered in the result register, and a full, stalled result register holds
// a next item in the input register. Throughput is one item per cycle while no
// such stall holds it; the state update sits between the two registers. Load items
// produce no result. Reset clears the run state: empty mask, empty pattern next.
module submask_candidate_generator import scg_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	logic    valid_s1;
	item_t   item_s1;
	mask_t   held_mask_q;
	cnt_t    mask_ones_q;
	mask_t   pattern_q;
	cnt_t    weight_q;
	logic    started_q;
	logic    result_valid_q;
	result_t result_q;

	logic    s1_next;
	logic    out_free;
	logic    s1_go;
	logic    take;
	mask_t   adv_pattern;
	cnt_t    adv_weight;
	mask_t   step_pattern;
	cnt_t    step_weight;
	mask_t   candidate;

	scg_advance u_advance (
		.pattern      (pattern_q),
		.weight       (weight_q),
		.ones         (mask_ones_q),
		.next_pattern (adv_pattern),
		.next_weight  (adv_weight)
	);

	scg_deposit u_deposit (
		.bits      (step_pattern),
		.positions (held_mask_q),
		.deposited (candidate)
	);

	always_comb begin
		s1_next      = (item_s1.mode == ModeNext);
		out_free     = !result_valid_q || !result_stall;
		s1_go        = valid_s1 && (!s1_next || out_free);
		item_stall   = valid_s1 && !s1_go;
		take         = item_valid && !item_stall;
		step_pattern = started_q ? adv_pattern : pattern_q;
		step_weight  = started_q ? adv_weight : weight_q;
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			held_mask_q    <= '0;
			mask_ones_q    <= '0;
			pattern_q      <= '0;
			weight_q       <= '0;
			started_q      <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (s1_go) begin
				valid_s1 <= 1'b0;
			end
			if (s1_go) begin
				if (!s1_next) begin
					held_mask_q <= item_s1.mask;
					mask_ones_q <= count_ones(item_s1.mask);
					pattern_q   <= '0;
					weight_q    <= '0;
					started_q   <= 1'b0;
				end else begin
					pattern_q <= step_pattern;
					weight_q  <= step_weight;
					started_q <= 1'b1;
				end
			end
			if (s1_go && s1_next) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= item;
		end
		if (s1_go && s1_next) begin
			result_q.candidate <= candidate;
			result_q.weight    <= step_weight;
			result_q.last      <= (step_weight == mask_ones_q);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		s1_go && s1_next |=> (result.candidate & ~held_mask_q) == '0)
		else $error("Candidate has a bit outside the held mask.");

	assert property (@(posedge clk) disable iff (!arst_n)
		s1_go && s1_next |=> cnt_t'($countones(result.candidate)) == result.weight)
		else $error("Candidate weight does not match its number of ones.");

	assert property (@(posedge clk) disable iff (!arst_n)
		weight_q <= mask_ones_q)
		else $error("Pattern weight exceeds the number of mask ones.");

	assert property (@(posedge clk) disable iff (!arst_n)
		s1_go && !s1_next |=> !started_q && pattern_q == '0 && weight_q == '0)
		else $error("Load did not restart the run at the empty pattern.");

endmodule

// ===== tb/scg_candidate_check.sv =====
// Monitor that predicts the candidate sequence and checks every result transfer against it.
module scg_candidate_check import scg_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	input  logic    item_stall,
	input  item_t   item,
	input  logic    result_valid,
	input  logic    result_stall,
	input  result_t result,
	output int      errors,
	output int      pending
);

	mask_t       held_mask;
	cnt_t        mask_ones;
	logic [31:0] pattern;
	cnt_t        pattern_ones;
	logic        started;
	result_t     expected_results[$];

	function automatic cnt_t popcount(mask_t v);
		cnt_t n;
		n = '0;
		for (int i = 0; i < MaskWidth; i++) begin
			if (v[i]) n = n + 1'b1;
		end
		return n;
	endfunction

	function automatic logic [31:0] ones_below(cnt_t n);
		return (32'd1 << n) - 32'd1;
	endfunction

	function automatic mask_t deposit_bits(logic [31:0] bits, mask_t m);
		mask_t r;
		int    j;
		r = '0;
		j = 0;
		for (int p = 0; p < MaskWidth; p++) begin
			if (m[p]) begin
				r[p] = bits[j];
				j++;
			end
		end
		return r;
	endfunction

	task automatic advance_pattern();
		logic [31:0] top;
		logic [31:0] low;
		logic [31:0] sum;
		if (pattern_ones >= mask_ones) begin
			pattern = '0;
			pattern_ones = '0;
		end else begin
			top = (pattern_ones == 0) ? 32'd0 :
				ones_below(pattern_ones) << (mask_ones - pattern_ones);
			if (pattern == top) begin
				pattern_ones = pattern_ones + 1'b1;
				pattern = ones_below(pattern_ones);
			end else begin
				low = pattern & (~pattern + 32'd1);
				sum = pattern + low;
				pattern = (((sum ^ pattern) >> 2) / low) | sum;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		result_t got;
		if (!arst_n) begin
			held_mask = '0;
			mask_ones = '0;
			pattern = '0;
			pattern_ones = '0;
			started = 1'b0;
			expected_results.delete();
			errors = 0;
		end else begin
			if (result_valid && !result_stall) begin
				got = result;
				if (expected_results.size() == 0) begin
					if (errors < 10) begin
						$display("unexpected result: candidate %h weight %0d last %0d",
							got.candidate, got.weight, got.last);
					end
					errors++;
				end else begin
					want = expected_results.pop_front();
					if (got.candidate !== want.candidate || got.weight !== want.weight ||
							got.last !== want.last) begin
						if (errors < 10) begin
							$write("mismatch: expected candidate %h weight %0d last %0d, ",
								want.candidate, want.weight, want.last);
							$display("got candidate %h weight %0d last %0d",
								got.candidate, got.weight, got.last);
						end
						errors++;
					end
				end
			end
			if (item_valid && !item_stall) begin
				if (item.mode == ModeLoad) begin
					held_mask = item.mask;
					mask_ones = popcount(item.mask);
					pattern = '0;
					pattern_ones = '0;
					started = 1'b0;
				end else begin
					if (started) advance_pattern();
					else started = 1'b1;
					want.candidate = deposit_bits(pattern, held_mask);
					want.weight = pattern_ones;
					want.last = (pattern_ones == mask_ones);
					expected_results.insert(expected_results.size(), want);
				end
			end
		end
		pending = expected_results.size();
	end

endmodule

// ===== tb/tb_submask_candidate_generator.sv =====
// Testbench top for the submask candidate generator: stimulus, flow control and verdict.
module tb_submask_candidate_generator;
	import scg_pkg::*;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    item_valid = 1'b0;
	logic    item_stall;
	item_t   item = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	int errors;
	int pending;
	int sent = 0;
	int quiet_cycles = 0;
	bit idle_on = 1'b1;
	bit quiet = 1'b0;

	submask_candidate_generator DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	scg_candidate_check candidate_check (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.errors(errors),
		.pending(pending)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic send(input mode_t m, input mask_t v);
		int gap;
		@(negedge clk);
		if (!quiet && idle_on && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 18);
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid <= 1'b1;
		item <= {m, v};
		@(posedge clk);
		while (item_stall) @(posedge clk);
		sent++;
	endtask

	task automatic request_next(input int n);
		repeat (n) send(ModeNext, mask_t'($urandom));
	endtask

	initial begin
		int burst;
		burst = 0;
		forever begin
			@(negedge clk);
			if (!quiet && idle_on && burst == 0 && $urandom_range(0, 11) == 0) begin
				burst = $urandom_range(1, 18);
			end
			if (burst > 0) begin
				result_stall <= 1'b1;
				burst--;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= 1000) begin
			$display("tb_submask_candidate_generator: FAIL");
			$finish;
		end
	end

	initial begin
		mask_t m;
		int    k;
		int    ones;
		int    pos;
		int    choice;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// The empty mask after reset, then runs that cross weights and wrap around.
		request_next(2);
		send(ModeLoad, 16'h8001);
		request_next(5);
		send(ModeLoad, 16'h0000);
		request_next(2);
		send(ModeLoad, 16'hFFFF);
		request_next(3);
		send(ModeLoad, 16'h0001);
		send(ModeLoad, 16'h8000);
		request_next(3);
		send(ModeLoad, 16'h0700);
		request_next(4);

		while (sent < 1000) begin
			if (sent >= 850) quiet = 1'b1;
			idle_on = ((sent / 120) % 3) != 2;
			choice = $urandom_range(0, 9);
			if (choice < 8) begin
				k = ($urandom_range(0, 19) == 0) ? $urandom_range(7, 8) : $urandom_range(0, 6);
				m = '0;
				ones = 0;
				while (ones < k) begin
					pos = $urandom_range(0, MaskWidth - 1);
					if (!m[pos]) begin
						m[pos] = 1'b1;
						ones++;
					end
				end
				send(ModeLoad, m);
				request_next((1 << k) + $urandom_range(0, 3));
			end else if (choice == 8) begin
				send(ModeLoad, mask_t'($urandom));
				request_next($urandom_range(0, 10));
			end else begin
				request_next($urandom_range(1, 4));
			end
		end

		@(negedge clk);
		item_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		if (errors == 0) begin
			$display("tb_submask_candidate_generator: PASS");
		end else begin
			$display("tb_submask_candidate_generator: FAIL");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/scg_pkg.sv
sv/scg_advance.sv
sv/scg_deposit.sv
sv/submask_candidate_generator.sv
tb/scg_candidate_check.sv
tb/tb_submask_candidate_generator.sv
